### sv/ggeb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ggeb_pkg
// Shared constants for the grid graph edge builder: register indexes and the
// fixed widths of the configuration and result fields.
// ----------------------------------------------------------------------------
package ggeb_pkg;

	localparam int CFG_DATA_W  = 9;
	localparam int CFG_INDEX_W = 1;
	localparam int OUT_INDEX_W = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS    = 1'd1;

	// Neighbour entry as seen by the edge logic
	typedef struct packed {
		logic                   edge_ok;
		logic [OUT_INDEX_W-1:0] index;
	} edge_out_t;

endpackage
`default_nettype wire

### sv/ggeb_line_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ggeb_line_cell
// One column slot of the previous-row line. On every transfer the slot takes
// its right neighbour's entry, or the fresh entry when it is the tail slot.
// ----------------------------------------------------------------------------
module ggeb_line_cell #(
	parameter int WIDTH = 17
) (
	input  wire logic             clk,
	input  wire logic             shift,
	input  wire logic             tail,
	input  wire logic [WIDTH-1:0] next_entry,
	input  wire logic [WIDTH-1:0] new_entry,
	output logic      [WIDTH-1:0] entry
);

	logic [WIDTH-1:0] entry_q;

	// Payload only: a slot is never read before the row above has written it
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= tail ? new_entry : next_entry;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

### sv/grid_graph_edge_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_graph_edge_builder
// Raster-order occupancy cells in, one node/edge record out per cell. Previous
// row entries travel down a chain of line cells so the slot above sits at the
// head and the slot above-right right behind it.
// ----------------------------------------------------------------------------
// Latency: result valid the cycle after the cell transfer.
// Throughput: one cell per cycle; set by the single output register, which
//   keeps taking cells while result_stall is low.
// Reset: counters and neighbour marks cleared, grid size set to 256 x 256 (clamped);
//   the line cells are not reset and no clearing pass runs.
// Any configuration write restarts the grid at cell zero.
module grid_graph_edge_builder
	import ggeb_pkg::*;
#(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256,
	parameter int INDEX_BITS  = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   cell_valid,
	output logic                        cell_stall,
	input  wire logic                   cell_usable,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic                        node_valid,
	output logic [OUT_INDEX_W-1:0]      node_index,
	output logic                        left_edge,
	output logic [OUT_INDEX_W-1:0]      left_index,
	output logic                        up_edge,
	output logic [OUT_INDEX_W-1:0]      up_index,
	output logic                        up_left_edge,
	output logic [OUT_INDEX_W-1:0]      up_left_index,
	output logic                        up_right_edge,
	output logic [OUT_INDEX_W-1:0]      up_right_index,
	output logic                        grid_end
);

	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int EW = INDEX_BITS + 1;          // node bit on top of the index
	localparam int COL_RST = (MAX_COLUMNS < 256) ? MAX_COLUMNS - 1 : 255;
	localparam int ROW_RST = (MAX_ROWS < 256) ? MAX_ROWS - 1 : 255;

	logic [CW-1:0] col_last_q, col_q;
	logic [RW-1:0] row_last_q, row_q;
	logic [EW-1:0] next_q;                       // INDEX_BITS+1: top bit = space full
	logic [EW-1:0] left_q, up_left_q;

	logic          advance, xfer, has_left, has_up, has_right, last, grant;
	logic [EW-1:0] new_entry, up_entry, up_right_entry;
	logic [EW-1:0] line [MAX_COLUMNS];

	edge_out_t     e_left, e_up, e_ul, e_ur;

	assign advance    = !result_valid || !result_stall;
	assign cell_stall = !advance;
	assign xfer       = cell_valid && advance;

	// ---------------- line of previous-row cells
	for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_line
		logic [EW-1:0] nxt;
		if (k < MAX_COLUMNS - 1) begin : g_mid
			assign nxt = line[k+1];
		end else begin : g_end
			assign nxt = new_entry;
		end
		ggeb_line_cell #(.WIDTH(EW)) u_cell (
			.clk        (clk),
			.shift      (xfer),
			.tail       (col_last_q == CW'(k)),
			.next_entry (nxt),
			.new_entry  (new_entry),
			.entry      (line[k])
		);
	end

	assign up_entry       = line[0];
	assign up_right_entry = (MAX_COLUMNS > 1) ? line[1 % MAX_COLUMNS] : '0;

	// ---------------- per-cell decisions
	assign has_left  = col_q != '0;
	assign has_up    = row_q != '0;
	assign has_right = col_q != col_last_q;
	assign last      = !has_right && (row_q == row_last_q);
	assign grant     = cell_usable && !next_q[INDEX_BITS];
	assign new_entry = grant ? {1'b1, next_q[INDEX_BITS-1:0]} : '0;

	function automatic edge_out_t pick(input logic ok, input logic [EW-1:0] ent);
		edge_out_t r;
		r.edge_ok = ok && ent[INDEX_BITS];
		r.index   = r.edge_ok ? OUT_INDEX_W'(ent[INDEX_BITS-1:0]) : '0;
		return r;
	endfunction

	assign e_left = pick(grant && has_left, left_q);
	assign e_up   = pick(grant && has_up, up_entry);
	assign e_ul   = pick(grant && has_up && has_left, up_left_q);
	assign e_ur   = pick(grant && has_up && has_right, up_right_entry);

	// ---------------- state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= CW'(COL_RST);
			row_last_q <= RW'(ROW_RST);
			col_q      <= '0;
			row_q      <= '0;
			next_q     <= '0;
			left_q     <= '0;
			up_left_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GRID_COLUMNS: begin
					if (cfg_data == '0)
						col_last_q <= '0;
					else if (cfg_data > MAX_COLUMNS)
						col_last_q <= CW'(MAX_COLUMNS - 1);
					else
						col_last_q <= CW'(cfg_data - 9'd1);
				end
				REG_GRID_ROWS: begin
					if (cfg_data == '0)
						row_last_q <= '0;
					else if (cfg_data > MAX_ROWS)
						row_last_q <= RW'(MAX_ROWS - 1);
					else
						row_last_q <= RW'(cfg_data - 9'd1);
				end
				default: ;
			endcase
			col_q     <= '0;
			row_q     <= '0;
			next_q    <= '0;
			left_q    <= '0;
			up_left_q <= '0;
		end else if (xfer) begin
			if (grant)
				next_q <= next_q + EW'(1);
			if (last) begin
				col_q     <= '0;
				row_q     <= '0;
				next_q    <= '0;
				left_q    <= '0;
				up_left_q <= '0;
			end else if (!has_right) begin
				col_q     <= '0;
				row_q     <= row_q + RW'(1);
				left_q    <= '0;
				up_left_q <= '0;
			end else begin
				col_q     <= col_q + CW'(1);
				left_q    <= new_entry;
				up_left_q <= up_entry;
			end
		end
	end

	// ---------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (advance)
			result_valid <= cell_valid;
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			node_valid     <= grant;
			node_index     <= grant ? OUT_INDEX_W'(next_q[INDEX_BITS-1:0]) : '0;
			left_edge      <= e_left.edge_ok;
			left_index     <= e_left.index;
			up_edge        <= e_up.edge_ok;
			up_index       <= e_up.index;
			up_left_edge   <= e_ul.edge_ok;
			up_left_index  <= e_ul.index;
			up_right_edge  <= e_ur.edge_ok;
			up_right_index <= e_ur.index;
			grid_end       <= last;
		end
	end

	// ---------------- checks
	a_no_edge_without_node: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !node_valid |->
			!(left_edge || up_edge || up_left_edge || up_right_edge))
		else $error("edge reported for a cell that is not a node");

	a_wrap_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && last |=> col_q == '0 && row_q == '0 && next_q == '0)
		else $error("grid did not restart after its last cell");

	a_counter_cap: assert property (@(posedge clk) disable iff (!arst_n)
		!next_q[INDEX_BITS] || next_q[INDEX_BITS-1:0] == '0)
		else $error("node counter ran past the index space");

	a_column_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= col_last_q)
		else $error("column position beyond the row length");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cell_stall |-> result_valid)
		else $error("cell transfer held off with an empty output register");

endmodule
`default_nettype wire
